[src/lsc_pkg.sv]
// Shared types and constants of the layered sprite compositor.
// Used by the controller, the datapath and the top level; no dependencies.
package lsc_pkg;

	// Opcodes of an input item
	localparam logic [2:0] OP_PIXEL  = 3'd0;
	localparam logic [2:0] OP_MOTION = 3'd1;
	localparam logic [2:0] OP_SIZE   = 3'd2;
	localparam logic [2:0] OP_FRAME  = 3'd3;
	localparam logic [2:0] OP_QUERY  = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] CFG_CANVAS_W = 2'd0;
	localparam logic [1:0] CFG_CANVAS_H = 2'd1;
	localparam logic [1:0] CFG_BG_RGB   = 2'd2;
	localparam logic [1:0] CFG_FPS      = 2'd3;

	localparam logic [31:0] OPAQUE   = 32'hFF00_0000;
	localparam logic [31:0] RGB_MASK = 32'h00FF_FFFF;

	// Kinematic numerator, its magnitude, and the 2*r*r denominator
	localparam int NUM_W     = 51;
	localparam int MAG_W     = 50;
	localparam int DEN_W     = 18;
	localparam int DIV_STEPS = MAG_W;
	localparam int CNT_W     = 6;

	// Operand pair that the shared multiplier works on
	typedef enum logic [2:0] {
		MUL_RR,
		MUL_RF,
		MUL_FF,
		MUL_S,
		MUL_V,
		MUL_A
	} mul_sel_t;

	typedef struct packed {
		logic     cap_in;
		logic     wr_pixel;
		logic     wr_motion;
		logic     wr_size;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     axis;
		logic     acc_clr;
		logic     div_start;
		logic     div_step;
		logic     pos_wr;
		logic     slot_top;
		logic     slot_zero;
		logic     slot_up;
		logic     slot_dn;
		logic     mem_rd;
		logic     res_bg;
		logic     res_sprite;
		logic     out_load;
	} lsc_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       canvas_ok;
		logic       box_hit;
		logic       alpha_hit;
		logic       slot_is_last;
		logic       slot_is_zero;
		logic       out_free;
	} lsc_status_t;

endpackage

[src/lsc_stream_if.sv]
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing; the top level takes them as ports.
interface lsc_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic [3:0]         slot;
	logic [15:0]        index;
	logic [31:0]        color_in;
	logic signed [15:0] coord_x;
	logic signed [15:0] coord_y;
	logic signed [15:0] vel_x;
	logic signed [15:0] vel_y;
	logic signed [15:0] acc_x;
	logic signed [15:0] acc_y;

	modport source(output valid, opcode, slot, index, color_in, coord_x, coord_y,
		vel_x, vel_y, acc_x, acc_y, input ready);
	modport sink(input valid, opcode, slot, index, color_in, coord_x, coord_y,
		vel_x, vel_y, acc_x, acc_y, output ready);
endinterface

interface lsc_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_out;
	logic        from_sprite;
	logic [3:0]  winning_slot;

	modport source(output valid, pixel_out, from_sprite, winning_slot, input ready);
	modport sink(input valid, pixel_out, from_sprite, winning_slot, output ready);
endinterface

[src/lsc_datapath.sv]
// Datapath: slot tables, sprite memory, shared multiplier, restoring divider,
// query compare and result register. Depends on lsc_pkg.
module lsc_datapath import lsc_pkg::*; #(
	parameter int SLOTS       = 16,
	parameter int SPRITE_SIDE = 64,
	parameter int COORD_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic [2:0]         opcode,
	input  logic [3:0]         slot,
	input  logic [15:0]        index,
	input  logic [31:0]        color_in,
	input  logic signed [15:0] coord_x,
	input  logic signed [15:0] coord_y,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	input  logic signed [15:0] acc_x,
	input  logic signed [15:0] acc_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        pixel_out,
	output logic               from_sprite,
	output logic [3:0]         winning_slot,
	input  lsc_cmd_t           cmd,
	output lsc_status_t        st
);

	localparam int PIX = SPRITE_SIDE * SPRITE_SIDE;
	localparam int AW  = (SLOTS * PIX > 1) ? $clog2(SLOTS * PIX) : 1;
	localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int DW  = $clog2(SPRITE_SIDE + 1);
	localparam int CW  = (SPRITE_SIDE > 1) ? $clog2(SPRITE_SIDE) : 1;
	localparam int PW  = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
	localparam logic [MAG_W-1:0] HI_MAG = MAG_W'((64'd1 << (COORD_BITS - 1)) - 64'd1);
	localparam logic [MAG_W-1:0] LO_MAG = HI_MAG + MAG_W'(1);

	// Captured input item
	logic [2:0]         op_q;
	logic [3:0]         slot_in_q;
	logic [15:0]        idx_q;
	logic [31:0]        color_q;
	logic signed [15:0] cx_q, cy_q, vx_in_q, vy_in_q, ax_in_q, ay_in_q;

	// Configuration
	logic [10:0] cw_q, ch_q;
	logic [23:0] bg_q;
	logic [7:0]  fps_q;

	// Slot tables
	logic signed [15:0]           sx_q [SLOTS];
	logic signed [15:0]           sy_q [SLOTS];
	logic signed [15:0]           vx_q [SLOTS];
	logic signed [15:0]           vy_q [SLOTS];
	logic signed [15:0]           ax_q [SLOTS];
	logic signed [15:0]           ay_q [SLOTS];
	logic [DW-1:0]                dw_q [SLOTS];
	logic [DW-1:0]                dh_q [SLOTS];
	logic signed [COORD_BITS-1:0] px_q [SLOTS];
	logic signed [COORD_BITS-1:0] py_q [SLOTS];

	logic [SW-1:0] scnt_q;
	logic [SW-1:0] sidx;
	logic          slot_ok, idx_ok;

	// Multiplier and accumulator
	logic [7:0]               rate;
	logic signed [16:0]       ma;
	logic signed [33:0]       mb;
	logic signed [NUM_W-1:0]  prod_s1;
	mul_sel_t                 sel_s1;
	logic                     vld_s1;
	logic [DEN_W-1:0]         den_q;
	logic [24:0]              rf2_q;
	logic [31:0]              ff_q;
	logic signed [NUM_W-1:0]  acc_q;
	logic signed [NUM_W-1:0]  acc_abs;

	// Divider
	logic                     neg_q;
	logic [MAG_W-1:0]         quo_q;
	logic [DEN_W-1:0]         rem_q;
	logic [DEN_W:0]           rem_sh, rem_diff;
	logic                     rem_ge;
	logic signed [COORD_BITS-1:0] pos_val;

	// Query
	logic signed [PW-1:0] dx, dy;
	logic [AW-1:0]        waddr, raddr;
	logic [31:0]          mem [SLOTS * PIX];
	logic [31:0]          rd_q;
	logic [31:0]          res_pix_q;
	logic                 res_hit_q;
	logic [3:0]           res_slot_q;
	logic                 out_valid_q;

	function automatic logic [DW-1:0] clamp_size(input logic signed [15:0] v);
		if (v < 0) return '0;
		else if (int'(v) > SPRITE_SIDE) return DW'(SPRITE_SIDE);
		else return DW'(v);
	endfunction

	assign sidx    = SW'(slot_in_q);
	assign slot_ok = int'(slot_in_q) < SLOTS;
	assign idx_ok  = int'(idx_q) < PIX;
	assign rate    = (fps_q == 8'd0) ? 8'd1 : fps_q;

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			op_q      <= opcode;
			slot_in_q <= slot;
			idx_q     <= index;
			color_q   <= color_in;
			cx_q      <= coord_x;
			cy_q      <= coord_y;
			vx_in_q   <= vel_x;
			vy_in_q   <= vel_y;
			ax_in_q   <= acc_x;
			ay_in_q   <= acc_y;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q  <= 11'd640;
			ch_q  <= 11'd480;
			bg_q  <= 24'd0;
			fps_q <= 8'd30;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CANVAS_W: cw_q  <= cfg_data[10:0];
				CFG_CANVAS_H: ch_q  <= cfg_data[10:0];
				CFG_BG_RGB:   bg_q  <= cfg_data;
				CFG_FPS:      fps_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Saturate the divided position to the coordinate range
	always_comb begin
		if (!neg_q) pos_val = (quo_q > HI_MAG) ? COORD_BITS'(HI_MAG) : COORD_BITS'(quo_q);
		else pos_val = (quo_q > LO_MAG) ? COORD_BITS'(LO_MAG) : COORD_BITS'(-quo_q);
	end

	// Slot tables: motion, size and frame positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				sx_q[i] <= '0;
				sy_q[i] <= '0;
				vx_q[i] <= '0;
				vy_q[i] <= '0;
				ax_q[i] <= '0;
				ay_q[i] <= '0;
				dw_q[i] <= '0;
				dh_q[i] <= '0;
				px_q[i] <= '0;
				py_q[i] <= '0;
			end
		end else begin
			if (cmd.wr_motion && slot_ok) begin
				sx_q[sidx] <= cx_q;
				sy_q[sidx] <= cy_q;
				vx_q[sidx] <= vx_in_q;
				vy_q[sidx] <= vy_in_q;
				ax_q[sidx] <= ax_in_q;
				ay_q[sidx] <= ay_in_q;
			end
			if (cmd.wr_size && slot_ok) begin
				dw_q[sidx] <= clamp_size(cx_q);
				dh_q[sidx] <= clamp_size(cy_q);
			end
			if (cmd.pos_wr) begin
				if (cmd.axis) py_q[scnt_q] <= pos_val;
				else px_q[scnt_q] <= pos_val;
			end
		end
	end

	// Slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scnt_q <= '0;
		end else if (cmd.slot_top) begin
			scnt_q <= SW'(SLOTS - 1);
		end else if (cmd.slot_zero) begin
			scnt_q <= '0;
		end else if (cmd.slot_up) begin
			scnt_q <= scnt_q + SW'(1);
		end else if (cmd.slot_dn) begin
			scnt_q <= scnt_q - SW'(1);
		end
	end

	// Select multiplier operands
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.mul_sel)
			MUL_RR: begin
				ma = {9'd0, rate};
				mb = {26'd0, rate};
			end
			MUL_RF: begin
				ma = {9'd0, rate};
				mb = {18'd0, idx_q};
			end
			MUL_FF: begin
				ma = {1'b0, idx_q};
				mb = {18'd0, idx_q};
			end
			MUL_S: begin
				ma = cmd.axis ? 17'(sy_q[scnt_q]) : 17'(sx_q[scnt_q]);
				mb = {16'd0, den_q};
			end
			MUL_V: begin
				ma = cmd.axis ? 17'(vy_q[scnt_q]) : 17'(vx_q[scnt_q]);
				mb = {9'd0, rf2_q};
			end
			MUL_A: begin
				ma = cmd.axis ? 17'(ay_q[scnt_q]) : 17'(ax_q[scnt_q]);
				mb = {2'd0, ff_q};
			end
			default: ;
		endcase
	end

	// Multiply, then store a frame constant or add into the numerator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		sel_s1  <= cmd.mul_sel;
		if (cmd.acc_clr) acc_q <= '0;
		if (vld_s1) begin
			case (sel_s1)
				MUL_RR: den_q <= {1'b0, prod_s1[15:0], 1'b0};
				MUL_RF: rf2_q <= {prod_s1[23:0], 1'b0};
				MUL_FF: ff_q  <= prod_s1[31:0];
				default: acc_q <= acc_q + prod_s1;
			endcase
		end
	end

	// Restoring divider, one quotient bit per step
	assign acc_abs  = acc_q[NUM_W-1] ? -acc_q : acc_q;
	assign rem_sh   = {rem_q, quo_q[MAG_W-1]};
	assign rem_ge   = rem_sh >= {1'b0, den_q};
	assign rem_diff = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q <= acc_q[NUM_W-1];
			quo_q <= acc_abs[MAG_W-1:0];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], rem_ge};
		end
	end

	// Sprite memory: one write port, one registered read port
	assign dx    = PW'(cx_q) - PW'(px_q[scnt_q]);
	assign dy    = PW'(cy_q) - PW'(py_q[scnt_q]);
	assign waddr = AW'(slot_in_q) * AW'(PIX) + AW'(idx_q);
	assign raddr = AW'(scnt_q) * AW'(PIX) + AW'(dy[CW-1:0]) * AW'(SPRITE_SIDE)
		+ AW'(dx[CW-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.wr_pixel && slot_ok && idx_ok) mem[waddr] <= color_q;
		if (cmd.mem_rd) rd_q <= mem[raddr];
	end

	// Hold the query result until the output register frees up
	always_ff @(posedge clk) begin
		if (cmd.res_bg) begin
			res_pix_q  <= OPAQUE | {8'd0, bg_q};
			res_hit_q  <= 1'b0;
			res_slot_q <= 4'd0;
		end else if (cmd.res_sprite) begin
			res_pix_q  <= OPAQUE | (rd_q & RGB_MASK);
			res_hit_q  <= 1'b1;
			res_slot_q <= 4'(scnt_q);
		end
		if (cmd.out_load) begin
			pixel_out    <= res_pix_q;
			from_sprite  <= res_hit_q;
			winning_slot <= res_slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// Status toward the controller
	always_comb begin
		st.op           = op_q;
		st.canvas_ok    = !cx_q[15] && !cy_q[15] && ($unsigned(cx_q) < {5'd0, cw_q})
			&& ($unsigned(cy_q) < {5'd0, ch_q});
		st.box_hit      = (dw_q[scnt_q] != '0) && (dh_q[scnt_q] != '0) && !dx[PW-1]
			&& !dy[PW-1] && ($unsigned(dx) < PW'(dw_q[scnt_q]))
			&& ($unsigned(dy) < PW'(dh_q[scnt_q]));
		st.alpha_hit    = rd_q[31:24] != 8'd0;
		st.slot_is_last = scnt_q == SW'(SLOTS - 1);
		st.slot_is_zero = scnt_q == '0;
		st.out_free     = !out_valid_q || out_ready;
	end

endmodule

[src/lsc_ctrl.sv]
// Controller: sequences item decode, per-slot kinematics and the top-down query.
// Depends on lsc_pkg; drives the datapath through lsc_cmd_t.
module lsc_ctrl import lsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  lsc_status_t st,
	output lsc_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_PRE,
		S_MUL,
		S_WAIT,
		S_DSTART,
		S_DIV,
		S_POS,
		S_Q_LOOK,
		S_Q_CHK,
		S_DONE
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             axis_q;
	logic             ready_q;
	logic             accept;

	assign accept    = req_valid && ready_q;
	assign req_ready = ready_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.axis = axis_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.cap_in = accept;
				if (accept) state_d = S_DECODE;
			end
			S_DECODE: begin
				state_d = S_IDLE;
				case (st.op)
					OP_PIXEL:  cmd.wr_pixel  = 1'b1;
					OP_MOTION: cmd.wr_motion = 1'b1;
					OP_SIZE:   cmd.wr_size   = 1'b1;
					OP_FRAME: begin
						cmd.slot_zero = 1'b1;
						state_d = S_PRE;
					end
					OP_QUERY: begin
						cmd.slot_top = 1'b1;
						if (st.canvas_ok) begin
							state_d = S_Q_LOOK;
						end else begin
							cmd.res_bg = 1'b1;
							state_d = S_DONE;
						end
					end
					default: ;
				endcase
			end
			S_PRE: begin
				cmd.mul_en = 1'b1;
				case (cnt_q)
					CNT_W'(0): cmd.mul_sel = MUL_RR;
					CNT_W'(1): cmd.mul_sel = MUL_RF;
					default:   cmd.mul_sel = MUL_FF;
				endcase
				if (cnt_q == CNT_W'(2)) state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				case (cnt_q)
					CNT_W'(0): begin
						cmd.mul_sel = MUL_S;
						cmd.acc_clr = 1'b1;
					end
					CNT_W'(1): cmd.mul_sel = MUL_V;
					default:   cmd.mul_sel = MUL_A;
				endcase
				if (cnt_q == CNT_W'(2)) state_d = S_WAIT;
			end
			S_WAIT: state_d = S_DSTART;
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_POS;
			end
			S_POS: begin
				cmd.pos_wr = 1'b1;
				if (!axis_q) begin
					state_d = S_MUL;
				end else if (st.slot_is_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.slot_up = 1'b1;
					state_d = S_MUL;
				end
			end
			S_Q_LOOK: begin
				if (st.box_hit) begin
					cmd.mem_rd = 1'b1;
					state_d = S_Q_CHK;
				end else if (st.slot_is_zero) begin
					cmd.res_bg = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.slot_dn = 1'b1;
				end
			end
			S_Q_CHK: begin
				if (st.alpha_hit) begin
					cmd.res_sprite = 1'b1;
					state_d = S_DONE;
				end else if (st.slot_is_zero) begin
					cmd.res_bg = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.slot_dn = 1'b1;
					state_d = S_Q_LOOK;
				end
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, step counter, axis and ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			axis_q  <= 1'b0;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ready_q <= state_d == S_IDLE;
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + CNT_W'(1);
			if (state_q == S_POS) axis_q <= !axis_q;
		end
	end

`ifndef SYNTHESIS
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_DECODE)
		else $error("accepted item not decoded");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free)
		else $error("result loaded over a pending result");
	a_rd_box: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_rd |-> st.box_hit)
		else $error("sprite read outside the sprite box");
	a_axis_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> !axis_q)
		else $error("axis left on y at end of frame start");
`endif

endmodule

[src/layered_sprite_compositor.sv]
// Layered sprite compositor: controller plus datapath behind two valid/ready channels.
// Depends on lsc_pkg, lsc_stream_if, lsc_ctrl and lsc_datapath.
//
// Usage: items enter on req (opcode, slot, index, color and motion fields) and are
// accepted when req.valid and req.ready are both high. Only a pixel query (opcode 4)
// gives a result on rsp: the ARGB pixel with alpha 0xFF, whether a sprite won, and
// the winning slot. Write registers through cfg_we/cfg_index/cfg_data only while idle;
// the block itself does not enforce this. Items are taken one at a time. A query scans
// slots from the top down; a slot whose box covers the pixel also passes through a
// check state, as the sprite memory read is registered. A frame start runs the shared
// multiplier and a one-bit-per-cycle divider for each slot and axis. A finished result
// waits in the output register while rsp.ready is low; the next item is taken
// meanwhile, but a further query holds until that register frees.
// Reset clears the slot tables (all slots disabled, motion and positions zero) and
// loads the register defaults; the sprite memory is not cleared.
module layered_sprite_compositor import lsc_pkg::*; #(
	parameter int SLOTS       = 16,
	parameter int SPRITE_SIDE = 64,
	parameter int COORD_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	lsc_req_if.sink     req,
	lsc_rsp_if.source   rsp
);

	lsc_cmd_t    cmd;
	lsc_status_t st;

	// Sequencer
	lsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Storage and arithmetic
	lsc_datapath #(
		.SLOTS       (SLOTS),
		.SPRITE_SIDE (SPRITE_SIDE),
		.COORD_BITS  (COORD_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.opcode       (req.opcode),
		.slot         (req.slot),
		.index        (req.index),
		.color_in     (req.color_in),
		.coord_x      (req.coord_x),
		.coord_y      (req.coord_y),
		.vel_x        (req.vel_x),
		.vel_y        (req.vel_y),
		.acc_x        (req.acc_x),
		.acc_y        (req.acc_y),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.pixel_out    (rsp.pixel_out),
		.from_sprite  (rsp.from_sprite),
		.winning_slot (rsp.winning_slot),
		.cmd          (cmd),
		.st           (st)
	);

endmodule
